// ===== design/quadratic_root_solver_macros.svh =====
// Assertion helpers for the top-level solver design.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Checked only out of reset.
`define QRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("qrs assertion failed");

// Checked at every edge, reset included.
`define QRS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("qrs assertion failed");

`endif

// ===== design/qrs_pkg.sv =====
package qrs_pkg;

    localparam int COEF_WIDTH = 32;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TWO_REAL = 2'd0;
    localparam t_kind KIND_DOUBLE   = 2'd1;
    localparam t_kind KIND_COMPLEX  = 2'd2;
    localparam t_kind KIND_DEGEN    = 2'd3;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } t_in_item;

    typedef struct packed {
        t_kind                        root_kind;
        logic signed [COEF_WIDTH-1:0] first_value;
        logic signed [COEF_WIDTH-1:0] second_value;
        logic                         saturated;
    } t_out_item;

endpackage

// ===== design/qrs_sqrt_pipe.sv =====
module qrs_sqrt_pipe
    import qrs_pkg::*;
#(
    parameter int RAD_W = 65
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [RAD_W-1:0]         i_rad,
    output logic [(RAD_W+1)/2-1:0]   o_root
);
    localparam int SW = (RAD_W + 1) / 2;
    localparam int PW = 2 * SW;
    localparam int RW = SW + 3;

    // one root bit per stage, restoring form
    logic [PW-1:0] r_rad  [SW];
    logic [RW-1:0] r_rem  [SW];
    logic [SW-1:0] r_root [SW];

    logic [PW-1:0] w_rad  [SW+1];
    logic [RW-1:0] w_rem  [SW+1];
    logic [SW-1:0] w_root [SW+1];

    assign w_rad[0]  = PW'(i_rad);
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0] t_rem;
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] n_rem;
        logic [SW-1:0] n_root;

        always_comb begin
            t_rem  = {w_rem[k][RW-3:0], w_rad[k][PW-1:PW-2]};
            trial  = RW'({w_root[k], 2'b01});
            ge     = t_rem >= trial;
            n_rem  = ge ? (t_rem - trial) : t_rem;
            n_root = {w_root[k][SW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {w_rad[k][PW-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end

        assign w_rad[k+1]  = r_rad[k];
        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
    end

    assign o_root = w_root[SW];

endmodule

// ===== design/qrs_div_pipe.sv =====
module qrs_div_pipe
    import qrs_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    // one quotient bit per stage, restoring division
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    logic [NUM_W-1:0] w_num [NUM_W+1];
    logic [DEN_W-1:0] w_rem [NUM_W+1];
    logic [NUM_W-1:0] w_quo [NUM_W+1];
    logic [DEN_W-1:0] w_den [NUM_W+1];

    assign w_num[0] = i_num;
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   t_rem;
        logic [DEN_W:0]   t_diff;
        logic             ge;

        always_comb begin
            t_rem  = {w_rem[k], w_num[k][NUM_W-1]};
            t_diff = t_rem - {1'b0, w_den[k]};
            ge     = t_rem >= {1'b0, w_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= w_num[k] << 1;
                r_rem[k] <= ge ? t_diff[DEN_W-1:0] : t_rem[DEN_W-1:0];
                r_quo[k] <= {w_quo[k][NUM_W-2:0], ge};
                r_den[k] <= w_den[k];
            end
        end

        assign w_num[k+1] = r_num[k];
        assign w_rem[k+1] = r_rem[k];
        assign w_quo[k+1] = r_quo[k];
        assign w_den[k+1] = r_den[k];
    end

    assign o_quo = w_quo[NUM_W];

endmodule

// ===== design/quadratic_root_solver.sv =====
// Quadratic root solver, fixed point, one equation per transfer.
// Input channel: i_in_valid / o_in_stall carry coef_a, coef_b, coef_c (signed,
// FRAC_BITS fraction bits). Output channel: o_out_valid / i_out_stall carry
// root_kind, first_value, second_value and saturated.
// Throughput: one equation per cycle, sustained, while no result is held by i_out_stall.
// The path runs through stages 1 to 4 (sign normalisation, partial products,
// product sums, discriminant), the square-root pipe (one root bit per stage),
// two dividers in parallel (one quotient bit per stage), stage P and the
// output register.
// The whole pipeline moves as one: when the result in the output register is
// stalled, every stage holds and o_in_stall rises in the same cycle, so
// nothing is lost or repeated. Bubbles flow through as cleared valid bits.
// Reset clears all valid bits; no result appears until an equation has passed
// the full pipe. Payload registers are not reset.
// A zero coef_a yields the degenerate kind with zero values.
`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    localparam int W   = COEF_WIDTH;
    localparam int H   = (W + 1) / 2;
    localparam int DW  = 2 * W + 1;
    localparam int SW  = (DW + 1) / 2;
    localparam int QW  = SW + FRAC_BITS;
    localparam int EW  = QW + 2;
    localparam int MID = SW + QW;

    logic en;
    logic r_out_valid;
    t_out_item r_out;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stage 1: sign normalisation
    logic         n_aneg, n_braw, n_craw;
    logic [W-1:0] n_amag, n_bmag, n_cmag;
    logic         r1_v, r1_bneg, r1_cneg, r1_azero;
    logic [W-1:0] r1_amag, r1_bmag, r1_cmag;

    always_comb begin
        n_aneg = i_in_data.coef_a[W-1];
        n_braw = i_in_data.coef_b[W-1];
        n_craw = i_in_data.coef_c[W-1];
        n_amag = n_aneg ? W'(-i_in_data.coef_a) : W'(i_in_data.coef_a);
        n_bmag = n_braw ? W'(-i_in_data.coef_b) : W'(i_in_data.coef_b);
        n_cmag = n_craw ? W'(-i_in_data.coef_c) : W'(i_in_data.coef_c);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_amag  <= n_amag;
            r1_bmag  <= n_bmag;
            r1_cmag  <= n_cmag;
            r1_azero <= i_in_data.coef_a == '0;
            r1_bneg  <= n_aneg ? (!n_braw && n_bmag != '0) : n_braw;
            r1_cneg  <= n_aneg ? (!n_craw && n_cmag != '0) : n_craw;
        end
    end

    // stage 2: half-width partial products
    logic [H-1:0]   a_lo, a_hi, b_lo, b_hi, c_lo, c_hi;
    logic [2*H-1:0] r2_bll, r2_blh, r2_bhh, r2_all, r2_alh, r2_ahl, r2_ahh;
    logic           r2_v, r2_bneg, r2_cneg, r2_azero;
    logic [W-1:0]   r2_bmag;
    logic [W:0]     r2_den;

    assign a_lo = r1_amag[H-1:0];
    assign a_hi = H'(r1_amag[W-1:H]);
    assign b_lo = r1_bmag[H-1:0];
    assign b_hi = H'(r1_bmag[W-1:H]);
    assign c_lo = r1_cmag[H-1:0];
    assign c_hi = H'(r1_cmag[W-1:H]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_bll   <= b_lo * b_lo;
            r2_blh   <= b_lo * b_hi;
            r2_bhh   <= b_hi * b_hi;
            r2_all   <= a_lo * c_lo;
            r2_alh   <= a_lo * c_hi;
            r2_ahl   <= a_hi * c_lo;
            r2_ahh   <= a_hi * c_hi;
            r2_bmag  <= r1_bmag;
            r2_den   <= {r1_amag, 1'b0};
            r2_bneg  <= r1_bneg;
            r2_cneg  <= r1_cneg;
            r2_azero <= r1_azero;
        end
    end

    // stage 3: product sums
    logic [4*H-1:0] n_bb, n_ac;
    logic [2*W-1:0] r3_bb, r3_ac;
    logic           r3_v, r3_bneg, r3_cneg, r3_azero;
    logic [W-1:0]   r3_bmag;
    logic [W:0]     r3_den;

    always_comb begin
        n_bb = ((4*H)'(r2_bhh) << (2*H)) + ((4*H)'(r2_blh) << (H+1)) + (4*H)'(r2_bll);
        n_ac = ((4*H)'(r2_ahh) << (2*H)) + ((4*H)'(r2_alh) << H)
             + ((4*H)'(r2_ahl) << H) + (4*H)'(r2_all);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_bb    <= n_bb[2*W-1:0];
            r3_ac    <= n_ac[2*W-1:0];
            r3_bmag  <= r2_bmag;
            r3_den   <= r2_den;
            r3_bneg  <= r2_bneg;
            r3_cneg  <= r2_cneg;
            r3_azero <= r2_azero;
        end
    end

    // stage 4: discriminant magnitude and sign
    logic [DW:0]   bb_x, ac4_x, n_d;
    logic          n_dneg;
    logic [DW-1:0] r4_d;
    logic          r4_v, r4_bneg, r4_dneg, r4_dzero, r4_azero;
    logic [W-1:0]  r4_bmag;
    logic [W:0]    r4_den;

    always_comb begin
        bb_x  = (DW+1)'(r3_bb);
        ac4_x = (DW+1)'({r3_ac, 2'b00});
        n_dneg = 1'b0;
        if (r3_cneg) begin
            n_d = bb_x + ac4_x;
        end else if (bb_x >= ac4_x) begin
            n_d = bb_x - ac4_x;
        end else begin
            n_d    = ac4_x - bb_x;
            n_dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_d     <= n_d[DW-1:0];
            r4_dneg  <= n_dneg;
            r4_dzero <= n_d == '0;
            r4_bmag  <= r3_bmag;
            r4_den   <= r3_den;
            r4_bneg  <= r3_bneg;
            r4_azero <= r3_azero;
        end
    end

    // square root, then both quotients side by side
    logic [SW-1:0] root;
    logic [QW-1:0] p_mag, q_mag;
    logic [W-1:0]  r_sq_bmag [SW];
    logic [W:0]    r_sq_den  [SW];
    logic          r_mid_v   [MID];
    logic          r_mid_bneg[MID];
    logic          r_mid_dneg[MID];
    logic          r_mid_dzero[MID];
    logic          r_mid_azero[MID];

    qrs_sqrt_pipe #(.RAD_W(DW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_d),
        .o_root (root)
    );

    qrs_div_pipe #(.NUM_W(QW), .DEN_W(W+1)) u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (QW'(r_sq_bmag[SW-1]) << FRAC_BITS),
        .i_den (r_sq_den[SW-1]),
        .o_quo (p_mag)
    );

    qrs_div_pipe #(.NUM_W(QW), .DEN_W(W+1)) u_div_q (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (QW'(root) << FRAC_BITS),
        .i_den (r_sq_den[SW-1]),
        .o_quo (q_mag)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_bmag[0]   <= r4_bmag;
            r_sq_den[0]    <= r4_den;
            for (int i = 1; i < SW; i++) begin
                r_sq_bmag[i] <= r_sq_bmag[i-1];
                r_sq_den[i]  <= r_sq_den[i-1];
            end
            r_mid_bneg[0]  <= r4_bneg;
            r_mid_dneg[0]  <= r4_dneg;
            r_mid_dzero[0] <= r4_dzero;
            r_mid_azero[0] <= r4_azero;
            for (int i = 1; i < MID; i++) begin
                r_mid_bneg[i]  <= r_mid_bneg[i-1];
                r_mid_dneg[i]  <= r_mid_dneg[i-1];
                r_mid_dzero[i] <= r_mid_dzero[i-1];
                r_mid_azero[i] <= r_mid_azero[i-1];
            end
        end
    end

    // stage P: root kind and signed roots before clipping
    logic signed [EW-1:0] p_s, q_s;
    logic signed [EW-1:0] r5_first, r5_second;
    t_kind                r5_kind;
    logic                 r5_v;

    always_comb begin
        q_s = $signed(EW'(q_mag));
        p_s = r_mid_bneg[MID-1] ? $signed(EW'(p_mag)) : -$signed(EW'(p_mag));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mid_azero[MID-1]) begin
                r5_kind   <= KIND_DEGEN;
                r5_first  <= '0;
                r5_second <= '0;
            end else if (r_mid_dneg[MID-1]) begin
                r5_kind   <= KIND_COMPLEX;
                r5_first  <= p_s;
                r5_second <= q_s;
            end else if (r_mid_dzero[MID-1]) begin
                r5_kind   <= KIND_DOUBLE;
                r5_first  <= p_s;
                r5_second <= p_s;
            end else begin
                r5_kind   <= KIND_TWO_REAL;
                r5_first  <= p_s + q_s;
                r5_second <= p_s - q_s;
            end
        end
    end

    // output stage: clip to the coefficient range
    logic         fit1, fit2;
    logic [W-1:0] clip1, clip2;

    always_comb begin
        fit1  = (r5_first[EW-1:W-1] == '0) || (r5_first[EW-1:W-1] == '1);
        fit2  = (r5_second[EW-1:W-1] == '0) || (r5_second[EW-1:W-1] == '1);
        clip1 = fit1 ? r5_first[W-1:0]
                     : (r5_first[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
        clip2 = fit2 ? r5_second[W-1:0]
                     : (r5_second[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.root_kind    <= r5_kind;
            r_out.first_value  <= $signed(clip1);
            r_out.second_value <= $signed(clip2);
            r_out.saturated    <= !fit1 || !fit2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            for (int i = 0; i < MID; i++) begin
                r_mid_v[i] <= 1'b0;
            end
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_v        <= i_in_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r_mid_v[0]  <= r4_v;
            for (int i = 1; i < MID; i++) begin
                r_mid_v[i] <= r_mid_v[i-1];
            end
            r5_v        <= r_mid_v[MID-1];
            r_out_valid <= r5_v;
        end
    end

    `QRS_ASSERT(a_degen_zero, o_out_valid && o_out_data.root_kind == KIND_DEGEN |-> o_out_data.first_value == '0 && o_out_data.second_value == '0 && !o_out_data.saturated)
    `QRS_ASSERT(a_double_equal, o_out_valid && o_out_data.root_kind == KIND_DOUBLE |-> o_out_data.first_value == o_out_data.second_value)
    `QRS_ASSERT(a_real_order, o_out_valid && o_out_data.root_kind == KIND_TWO_REAL |-> o_out_data.first_value >= o_out_data.second_value)
    `QRS_ASSERT(a_imag_nonneg, o_out_valid && o_out_data.root_kind == KIND_COMPLEX |-> !o_out_data.second_value[W-1])
    `QRS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid)

endmodule

// ===== tb/sv/tb_quadratic_root_solver.sv =====
`timescale 1ns / 1ps

module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    quadratic_root_solver #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    t_out_item roots_pending[$];
    int        n_errors;
    int        idle_cycles;
    bit        no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        n_errors    = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
    end

    // Integer square root, floor, of a value below 2^82
    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 40; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] clip_q16(input logic signed [127:0] v,
                                                             inout logic sat);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = 128'sd2147483647;
        lo_lim = -128'sd2147483648;
        if (v > hi_lim) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < lo_lim) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[COEF_WIDTH-1:0];
    endfunction

    function automatic t_out_item solve_roots(input t_in_item eq);
        logic signed [127:0] a, b, c, disc, den, p, q, s, r1, r2;
        logic                sat;
        t_out_item           res;
        res = '0;
        sat = 1'b0;
        a = eq.coef_a;
        b = eq.coef_b;
        c = eq.coef_c;
        if (a == 0) begin
            res.root_kind = KIND_DEGEN;
            return res;
        end
        if (a < 0) begin
            a = -a;
            b = -b;
            c = -c;
        end
        disc = b * b - 4 * a * c;
        den  = 2 * a;
        p    = (-b * (128'sd1 <<< FRAC)) / den;
        s    = $signed(floor_sqrt(disc < 0 ? -disc : disc));
        q    = (s * (128'sd1 <<< FRAC)) / den;
        if (disc < 0) begin
            res.root_kind = KIND_COMPLEX;
            r1 = p;
            r2 = q;
        end else if (disc == 0) begin
            res.root_kind = KIND_DOUBLE;
            r1 = p;
            r2 = p;
        end else begin
            res.root_kind = KIND_TWO_REAL;
            r1 = p + q;
            r2 = p - q;
        end
        res.first_value  = clip_q16(r1, sat);
        res.second_value = clip_q16(r2, sat);
        res.saturated    = sat;
        return res;
    endfunction

    // Leaves valid high after the transfer so back-to-back items need no second assignment
    task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c);
        t_in_item eq;
        eq.coef_a = a;
        eq.coef_b = b;
        eq.coef_c = c;
        if (!no_gaps && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= eq;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) begin
                @(posedge i_clk);
                roots_pending.push_back(solve_roots(eq));
                break;
            end
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= !no_gaps && ($urandom_range(99) < 25);
    end

    // Output and input are stable by the falling edge; transfer happens at the next rise
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                if (roots_pending.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    n_errors++;
                end else begin
                    want = roots_pending.pop_front();
                    if (o_out_data.root_kind !== want.root_kind) begin
                        $display("%0t: root_kind expected %0d actual %0d", $time,
                                 want.root_kind, o_out_data.root_kind);
                        n_errors++;
                    end
                    if (o_out_data.first_value !== want.first_value) begin
                        $display("%0t: first_value expected %h actual %h", $time,
                                 want.first_value, o_out_data.first_value);
                        n_errors++;
                    end
                    if (o_out_data.second_value !== want.second_value) begin
                        $display("%0t: second_value expected %h actual %h", $time,
                                 want.second_value, o_out_data.second_value);
                        n_errors++;
                    end
                    if (o_out_data.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, o_out_data.saturated);
                        n_errors++;
                    end
                end
            end
        end
    end

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;
            2: return $signed($urandom_range(2 * 4096)) - 4096;
            3: return $urandom() >> $urandom_range(31);
            4: return $urandom() | 32'h8000_0000;
            default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    task automatic test_directed();
        send_equation(32'h0, 32'h0001_0000, 32'h0002_0000);
        send_equation(32'h0, 32'h8000_0000, 32'h7fff_ffff);
        send_equation(32'h0001_0000, 32'h0, 32'hffff_0000);
        send_equation(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
        send_equation(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_equation(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000);
        send_equation(32'h0001_0000, 32'h0, 32'h0);
        send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_equation(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_equation(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_equation(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
        send_equation(32'h0000_0001, 32'h8000_0000, 32'h0);
        send_equation(32'h0000_0001, 32'h0, 32'h7fff_ffff);
        send_equation(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_equation(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
        send_equation(32'h8000_0000, 32'h0, 32'h0);
        send_equation(32'h0004_0000, 32'h0004_0000, 32'h0001_0000);
        send_equation(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
    endtask

    task automatic test_random_mix(input int count);
        logic [31:0] k, m;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: send_equation(32'h0, pick_coef(), pick_coef());
                1, 2: begin
                    // b*b == 4ac for a double root
                    k = $urandom_range(1, 4000);
                    m = $urandom_range(0, 4000);
                    send_equation(k * k, (($urandom_range(1) ? -1 : 1) * 2 * k * m),
                                  ($urandom_range(1) ? m * m : m * m));
                end
                default: send_equation(pick_coef(), pick_coef(), pick_coef());
            endcase
        end
    endtask

    task automatic test_back_to_back(input int count);
        no_gaps = 1'b1;
        for (int i = 0; i < count; i++)
            send_equation(pick_coef(), pick_coef(), pick_coef());
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix(500);
        test_back_to_back(150);
        test_random_mix(300);
        i_in_valid <= 1'b0;
        while (roots_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && roots_pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
